// ----- rtl/core/ptrt_pkg.sv -----
// shared types and constants for the periodic task release table
package ptrt_pkg;

    localparam int NUM_TASKS = 8;
    localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int MASK_W    = 8;

    typedef enum logic [1:0] {
        REQ_REGISTER   = 2'd0,
        REQ_UNREGISTER = 2'd1,
        REQ_COMPARE    = 2'd2,
        REQ_NONE       = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_ZERO   = 2'd2,
        ST_BUSY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TW_NONE,
        TW_REGISTER,
        TW_UNREGISTER,
        TW_RELEASE
    } tbl_op_t;

    typedef struct packed {
        logic [15:0] rt;
        logic [15:0] per;
        logic [7:0]  flags;
    } slot_t;

    typedef struct packed {
        tbl_op_t          op;
        logic [IDX_W-1:0] idx;
        logic [15:0]      rt;
        logic [15:0]      per;
        logic [7:0]       flags;
    } tbl_wr_t;

    typedef struct packed {
        logic        due;
        logic        take_min;
        logic [15:0] rt_new;
    } alu_res_t;

endpackage

// ----- rtl/core/ptrt_req_if.sv -----
// request channel of the periodic task release table
interface ptrt_req_if import ptrt_pkg::*; ();
    logic        valid;
    logic        ready;
    req_type_t   req_type;
    logic [7:0]  task_index;
    logic [15:0] phasing;
    logic [15:0] period_in;
    logic [7:0]  task_flags;

    modport source (
        output valid, req_type, task_index, phasing, period_in, task_flags,
        input  ready
    );
    modport sink (
        input  valid, req_type, task_index, phasing, period_in, task_flags,
        output ready
    );
endinterface

// ----- rtl/core/ptrt_rsp_if.sv -----
// response channel of the periodic task release table
interface ptrt_rsp_if import ptrt_pkg::*; ();
    logic        valid;
    logic        ready;
    status_t     status;
    logic [15:0] next_compare;
    logic [7:0]  released_mask;

    modport source (
        output valid, status, next_compare, released_mask,
        input  ready
    );
    modport sink (
        input  valid, status, next_compare, released_mask,
        output ready
    );
endinterface

// ----- rtl/core/periodic_task_release_table.sv -----
// Periodic task release table: one slot per priority level, NUM_TASKS slots.
// A register or unregister request is decided in the cycle it is accepted and
// its response is ready in the next cycle. A compare event walks the slots one
// per cycle through a single shared add/compare unit, advancing every due task
// and tracking the earliest next release, then publishes the new compare time
// from S_FIN once the output register is free; req.ready is low throughout.
// The response sits in an output register; a new request is taken in S_IDLE
// while that register is empty or being drained.
module periodic_task_release_table import ptrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ptrt_req_if.sink  req,
    ptrt_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } state_t;

    localparam logic [7:0] NUM_TASKS_B = 8'(NUM_TASKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    state_t             state_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [15:0]        cmp_reg;
    logic [15:0]        earliest_reg;
    logic               any_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [MASK_W-1:0]  mask_next;
    logic               ov_reg;
    logic               ov_next;
    status_t            status_reg;
    logic [15:0]        next_cmp_reg;
    logic [MASK_W-1:0]  rel_mask_reg;

    logic               out_free;
    logic               accept;
    logic [IDX_W-1:0]   rd_idx;
    slot_t              rd_data;
    tbl_wr_t            wr;
    alu_res_t           alu;
    logic               in_range;
    logic [15:0]        per_scaled;
    logic [15:0]        first_scaled;
    status_t            idle_status;
    logic [15:0]        final_cmp;

    assign out_free  = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign rsp.valid         = ov_reg;
    assign rsp.status        = status_reg;
    assign rsp.next_compare  = next_cmp_reg;
    assign rsp.released_mask = rel_mask_reg;

    assign rd_idx = (state_reg == S_IDLE) ? req.task_index[IDX_W-1:0] : idx_reg;

    ptrt_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .wr      (wr)
    );

    ptrt_alu u_alu (
        .slot     (rd_data),
        .cmp_time (cmp_reg),
        .earliest (earliest_reg),
        .any      (any_reg),
        .res      (alu)
    );

    // scaling by four with 16-bit wrap
    assign first_scaled = {req.phasing[13:0], 2'b00};
    assign per_scaled   = {req.period_in[13:0], 2'b00};
    assign in_range     = (req.task_index < NUM_TASKS_B);
    assign final_cmp    = any_reg ? earliest_reg : cmp_reg;

    always_comb
    begin
        case (req.req_type)
            REQ_REGISTER:
            begin
                if (!in_range)
                    idle_status = ST_BOUNDS;
                else if (per_scaled == 16'd0)
                    idle_status = ST_ZERO;
                else if (rd_data.flags != 8'd0)
                    idle_status = ST_BUSY;
                else
                    idle_status = ST_OK;
            end
            REQ_UNREGISTER:
                idle_status = in_range ? ST_OK : ST_BOUNDS;
            default:
                idle_status = ST_OK;
        endcase
    end

    always_comb
    begin
        wr.op    = TW_NONE;
        wr.idx   = rd_idx;
        wr.rt    = alu.rt_new;
        wr.per   = per_scaled;
        wr.flags = req.task_flags | 8'h01;
        if (state_reg == S_IDLE)
        begin
            wr.rt = first_scaled;
            if (accept && req.req_type == REQ_REGISTER && idle_status == ST_OK)
                wr.op = TW_REGISTER;
            else if (accept && req.req_type == REQ_UNREGISTER && in_range)
                wr.op = TW_UNREGISTER;
        end
        else if (state_reg == S_WALK && alu.due)
        begin
            wr.op = TW_RELEASE;
        end
    end

    // slots beyond the mask width release without a mask bit
    always_comb
    begin
        mask_next = mask_reg;
        for (int b = 0; b < MASK_W; b++)
        begin
            if (alu.due && int'(idx_reg) == b)
                mask_next[b] = 1'b1;
        end
    end

    // output register: drained by rsp.ready, loaded by a finished request
    always_comb
    begin
        ov_next = ov_reg && !rsp.ready;
        if (state_reg == S_IDLE && accept && req.req_type != REQ_COMPARE)
            ov_next = 1'b1;
        else if (state_reg == S_FIN && out_free)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            cmp_reg      <= '0;
            earliest_reg <= '0;
            any_reg      <= 1'b0;
            mask_reg     <= '0;
            ov_reg       <= 1'b0;
            status_reg   <= ST_OK;
            next_cmp_reg <= '0;
            rel_mask_reg <= '0;
        end
        else
        begin
            ov_reg <= ov_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.req_type == REQ_COMPARE)
                        begin
                            idx_reg   <= '0;
                            any_reg   <= 1'b0;
                            mask_reg  <= '0;
                            state_reg <= S_WALK;
                        end
                        else
                        begin
                            status_reg   <= idle_status;
                            next_cmp_reg <= cmp_reg;
                            rel_mask_reg <= '0;
                        end
                    end
                end
                S_WALK:
                begin
                    if (alu.take_min)
                    begin
                        earliest_reg <= alu.rt_new;
                        any_reg      <= 1'b1;
                    end
                    mask_reg <= mask_next;
                    if (idx_reg == LAST_IDX)
                        state_reg <= S_FIN;
                    else
                        idx_reg <= idx_reg + IDX_W'(1);
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        status_reg   <= ST_OK;
                        cmp_reg      <= final_cmp;
                        next_cmp_reg <= final_cmp;
                        rel_mask_reg <= mask_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/ptrt_table.sv -----
// per-slot storage: release time, period, activation count and flags
module ptrt_table import ptrt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_idx,
    output slot_t            rd_data,
    input  tbl_wr_t          wr
);

    logic [15:0] rt_reg    [NUM_TASKS];
    logic [15:0] per_reg   [NUM_TASKS];
    logic [7:0]  cnt_reg   [NUM_TASKS];
    logic [7:0]  flags_reg [NUM_TASKS];

    assign rd_data.rt    = rt_reg[rd_idx];
    assign rd_data.per   = per_reg[rd_idx];
    assign rd_data.flags = flags_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                rt_reg[i]    <= '0;
                per_reg[i]   <= '0;
                cnt_reg[i]   <= '0;
                flags_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (wr.op)
                TW_REGISTER:
                begin
                    rt_reg[wr.idx]    <= wr.rt;
                    per_reg[wr.idx]   <= wr.per;
                    cnt_reg[wr.idx]   <= '0;
                    flags_reg[wr.idx] <= wr.flags;
                end
                TW_UNREGISTER:
                begin
                    flags_reg[wr.idx] <= '0;
                end
                TW_RELEASE:
                begin
                    rt_reg[wr.idx]  <= wr.rt;
                    cnt_reg[wr.idx] <= cnt_reg[wr.idx] + 8'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/ptrt_alu.sv -----
// shared slot unit: due test, period add and running minimum compare
module ptrt_alu import ptrt_pkg::*;
(
    input  slot_t       slot,
    input  logic [15:0] cmp_time,
    input  logic [15:0] earliest,
    input  logic        any,
    output alu_res_t    res
);

    logic in_use;

    always_comb
    begin
        in_use     = (slot.flags != 8'd0);
        res.due    = in_use && (slot.rt <= cmp_time);
        res.rt_new = res.due ? (slot.rt + slot.per) : slot.rt;
        // minimum is taken over the already advanced release time
        res.take_min = in_use && (!any || (res.rt_new < earliest));
    end

endmodule

// ----- rtl/core/ptrt_checker.sv -----
// port-level checks for the periodic task release table, bound to the top
module ptrt_checker import ptrt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input req_type_t   req_type,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input status_t     rsp_status,
    input logic [15:0] rsp_next_compare,
    input logic [7:0]  rsp_released_mask
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_next_compare) && $stable(rsp_released_mask))
        else $error("response changed while stalled");

    // a compare event keeps the block busy for the slot walk
    a_cmp_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_COMPARE |=> !req_ready)
        else $error("request taken during slot walk");

    // register, unregister and no-op requests answer in the next cycle
    a_tbl_resp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type != REQ_COMPARE |=> rsp_valid)
        else $error("missing response for table request");

    // only a successful request can release tasks
    a_mask_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_released_mask != 8'd0 |-> rsp_status == ST_OK)
        else $error("release mask with error status");

endmodule

bind periodic_task_release_table ptrt_checker u_ptrt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_type          (req.req_type),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_next_compare  (rsp.next_compare),
    .rsp_released_mask (rsp.released_mask)
);

// ----- verif/tb_top.sv -----
// self-checking testbench for the periodic task release table
module tb_top import ptrt_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SCALE       = 4;
    localparam logic [7:0] TRIGGER     = 8'h01;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         RANDOM_REQS = 650;
    localparam int         TAIL_CYCLES = 20;

    typedef struct {
        req_type_t   kind;
        logic [7:0]  idx;
        logic [15:0] phase;
        logic [15:0] period;
        logic [7:0]  flags;
        bit          drain_first;
    } task_req_t;

    typedef struct {
        status_t     status;
        logic [15:0] cmp;
        logic [7:0]  mask;
    } release_rsp_t;

    logic clk;
    logic rst_n;

    ptrt_req_if req_ch ();
    ptrt_rsp_if rsp_ch ();

    periodic_task_release_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the task table
    logic [15:0] rel_time [NUM_TASKS];
    logic [15:0] task_per [NUM_TASKS];
    logic [7:0]  act_cnt  [NUM_TASKS];
    logic [7:0]  slot_flg [NUM_TASKS];
    logic [15:0] cmp_time;

    task_req_t    pending_reqs [$];
    release_rsp_t expected_rsps [$];

    logic req_taken;
    int   req_gap;
    int   rsp_stall;
    bit   req_calm;
    bit   rsp_calm;
    int   mismatch_cnt;
    int   idle_cycles;
    int   n_kind [4];
    int   n_rsp;
    int   n_released;

    always #2 clk = ~clk;

    function automatic release_rsp_t predict_release(task_req_t r);
        release_rsp_t res;
        logic [15:0]  first_rel;
        logic [15:0]  scaled_per;
        logic [15:0]  earliest;
        bit           any_used;
        int           i;
        res.status = ST_OK;
        res.mask   = '0;
        first_rel  = r.phase * 16'(SCALE);
        scaled_per = r.period * 16'(SCALE);
        earliest   = '0;
        any_used   = 1'b0;
        case (r.kind)
            REQ_REGISTER:
            begin
                // bounds, then zero period, then busy
                if (r.idx >= NUM_TASKS)
                    res.status = ST_BOUNDS;
                else if (scaled_per == '0)
                    res.status = ST_ZERO;
                else if (slot_flg[r.idx] != '0)
                    res.status = ST_BUSY;
                else
                begin
                    rel_time[r.idx] = first_rel;
                    task_per[r.idx] = scaled_per;
                    act_cnt[r.idx]  = '0;
                    slot_flg[r.idx] = r.flags | TRIGGER;
                end
            end
            REQ_UNREGISTER:
            begin
                if (r.idx >= NUM_TASKS)
                    res.status = ST_BOUNDS;
                else
                    slot_flg[r.idx] = '0;
            end
            REQ_COMPARE:
            begin
                for (i = 0; i < NUM_TASKS; i++)
                begin
                    // plain unsigned due test, no wrap allowance
                    if (slot_flg[i] != '0 && rel_time[i] <= cmp_time)
                    begin
                        rel_time[i] = rel_time[i] + task_per[i];
                        act_cnt[i]  = act_cnt[i] + 8'd1;
                        if (i < MASK_W)
                            res.mask[i] = 1'b1;
                    end
                end
                for (i = 0; i < NUM_TASKS; i++)
                begin
                    if (slot_flg[i] != '0)
                    begin
                        if (!any_used || rel_time[i] < earliest)
                            earliest = rel_time[i];
                        any_used = 1'b1;
                    end
                end
                // empty table keeps the old compare time
                if (any_used)
                    cmp_time = earliest;
            end
            default:
            begin
            end
        endcase
        res.cmp = cmp_time;
        return res;
    endfunction

    function automatic int pick_gap(bit calm, int busy_pct);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r >= busy_pct)
            return 0;
        if (r < busy_pct / 10)
            return int'($urandom_range(8, 40));
        return int'($urandom_range(1, 3));
    endfunction

    task automatic queue_req(req_type_t kind, logic [7:0] idx, logic [15:0] phase,
                             logic [15:0] period, logic [7:0] flags, bit drain_first);
        task_req_t r;
        r.kind        = kind;
        r.idx         = idx;
        r.phase       = phase;
        r.period      = period;
        r.flags       = flags;
        r.drain_first = drain_first;
        pending_reqs.push_back(r);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        task_req_t nxt;
        if (rst_n)
        begin
            if ($urandom_range(0, 149) == 0)
                req_calm = !req_calm;
            if (!req_ch.valid || req_taken)
            begin
                if (req_taken)
                    req_gap = pick_gap(req_calm, 40);
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain_first && expected_rsps.size() != 0))
                begin
                    nxt = pending_reqs.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.req_type   <= nxt.kind;
                    req_ch.task_index <= nxt.idx;
                    req_ch.phasing    <= nxt.phase;
                    req_ch.period_in  <= nxt.period;
                    req_ch.task_flags <= nxt.flags;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // response back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 149) == 0)
                rsp_calm = !rsp_calm;
            if (rsp_stall == 0)
                rsp_stall = pick_gap(rsp_calm, 30);
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // monitor: predicts on each accepted request, checks each accepted response
    always @(posedge clk)
    begin
        task_req_t    seen;
        release_rsp_t want;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                seen.kind        = req_ch.req_type;
                seen.idx         = req_ch.task_index;
                seen.phase       = req_ch.phasing;
                seen.period      = req_ch.period_in;
                seen.flags       = req_ch.task_flags;
                seen.drain_first = 1'b0;
                expected_rsps.push_back(predict_release(seen));
                n_kind[int'(seen.kind)]++;
                moved = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                n_rsp++;
                if (expected_rsps.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: response with no request outstanding", $realtime);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    check_field("status", 16'(want.status), 16'(rsp_ch.status));
                    check_field("next_compare", want.cmp, rsp_ch.next_compare);
                    check_field("released_mask", 16'(want.mask), 16'(rsp_ch.released_mask));
                    n_released += $countones(want.mask);
                end
            end
            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        req_type_t   kind;
        logic [7:0]  idx;
        logic [15:0] phase;
        logic [15:0] period;
        int          n_random;
        int          pick;
        int          pick_per;

        clk               = 1'b0;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_REGISTER;
        req_ch.task_index = '0;
        req_ch.phasing    = '0;
        req_ch.period_in  = '0;
        req_ch.task_flags = '0;
        rsp_ch.ready      = 1'b0;
        req_taken         = 1'b0;
        req_gap           = 0;
        rsp_stall         = 0;
        req_calm          = 1'b0;
        rsp_calm          = 1'b0;
        mismatch_cnt      = 0;
        idle_cycles       = 0;
        n_rsp             = 0;
        n_released        = 0;
        n_kind            = '{default: 0};
        cmp_time          = '0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            rel_time[i] = '0;
            task_per[i] = '0;
            act_cnt[i]  = '0;
            slot_flg[i] = '0;
        end

        // directed: empty table, unknown request, bounds and zero period order, busy slot
        queue_req(REQ_COMPARE,    8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
        queue_req(REQ_NONE,       8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        queue_req(REQ_UNREGISTER, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
        queue_req(REQ_UNREGISTER, 8'h08, 16'h0000, 16'h0000, 8'h00, 1'b0);
        queue_req(REQ_UNREGISTER, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        queue_req(REQ_REGISTER,   8'hFF, 16'h0001, 16'h0000, 8'h00, 1'b0);
        queue_req(REQ_REGISTER,   8'h08, 16'h0001, 16'h0001, 8'h00, 1'b0);
        queue_req(REQ_REGISTER,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
        queue_req(REQ_REGISTER,   8'h00, 16'h0000, 16'h4000, 8'h00, 1'b0);
        queue_req(REQ_REGISTER,   8'h00, 16'h0000, 16'hC000, 8'h00, 1'b0);
        queue_req(REQ_REGISTER,   8'h00, 16'h0000, 16'h0001, 8'h00, 1'b0);
        queue_req(REQ_REGISTER,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
        queue_req(REQ_REGISTER,   8'h00, 16'h0002, 16'h0005, 8'h10, 1'b0);
        queue_req(REQ_REGISTER,   8'h07, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        queue_req(REQ_COMPARE,    8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1);
        queue_req(REQ_COMPARE,    8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        queue_req(REQ_REGISTER,   8'h03, 16'h4000, 16'h3FFF, 8'h80, 1'b0);
        queue_req(REQ_COMPARE,    8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
        queue_req(REQ_COMPARE,    8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
        queue_req(REQ_UNREGISTER, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
        queue_req(REQ_COMPARE,    8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
        queue_req(REQ_UNREGISTER, 8'h03, 16'h0000, 16'h0000, 8'h00, 1'b0);
        queue_req(REQ_UNREGISTER, 8'h07, 16'h0000, 16'h0000, 8'h00, 1'b0);
        queue_req(REQ_COMPARE,    8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);

        // random: mostly legal registers and compare events, some noise
        n_random = 0;
        while (n_random < RANDOM_REQS)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                idx = 8'($urandom_range(NUM_TASKS, 255));
            else
                idx = 8'($urandom_range(0, NUM_TASKS - 1));
            if ($urandom_range(0, 9) < 6)
                phase = 16'($urandom_range(0, 512));
            else
                phase = 16'($urandom);
            pick_per = $urandom_range(0, 19);
            if (pick_per == 0)
                period = {2'($urandom_range(0, 3)), 14'd0};
            else if (pick_per < 10)
                period = 16'($urandom_range(1, 64));
            else
                period = 16'($urandom);
            if (pick < 35)
                kind = REQ_REGISTER;
            else if (pick < 50)
                kind = REQ_UNREGISTER;
            else if (pick < 96)
                kind = REQ_COMPARE;
            else
                kind = REQ_NONE;
            queue_req(kind, idx, phase, period, 8'($urandom), (n_random % 160) == 159);
            if (kind != REQ_NONE)
                n_random++;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d register, %0d unregister, %0d compare and %0d no-op requests",
                 n_kind[REQ_REGISTER], n_kind[REQ_UNREGISTER], n_kind[REQ_COMPARE],
                 n_kind[REQ_NONE]);
        $display("%0d responses checked, %0d task releases, %0d mismatches",
                 n_rsp, n_released, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/ptrt_pkg.sv
rtl/core/ptrt_req_if.sv
rtl/core/ptrt_rsp_if.sv
rtl/core/ptrt_table.sv
rtl/core/ptrt_alu.sv
rtl/core/periodic_task_release_table.sv
rtl/core/ptrt_checker.sv
verif/tb_top.sv
